// ===== design/tak_pkg.sv =====
// Shared types, constants and arithmetic helpers for the tilt angle Kalman filter.
`default_nettype none
package tak_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int TBL_FRAC      = 24;
  localparam int CNT_W         = $clog2(CORDIC_STAGES);

  localparam logic signed [67:0] ONE_Q   = 68'sd1 <<< FRAC_BITS;
  localparam logic signed [67:0] ALIM    = 68'sd180 * ONE_Q;
  localparam logic signed [67:0] BLIM    = 68'sd2000 * ONE_Q;
  localparam logic signed [67:0] I32_MAX = 68'sd2147483647;
  localparam logic signed [67:0] I32_MIN = -68'sd2147483648;
  localparam logic [48:0]        K1_LIM  = 49'd1 << 27;

  typedef struct packed {
    logic               operation;
    logic signed [15:0] accel_a;
    logic signed [15:0] accel_b;
    logic signed [15:0] gyro_rate;
  } in_item_t;

  typedef struct packed {
    logic signed [24:0] angle_estimate;
    logic signed [27:0] bias_estimate;
  } out_item_t;

  typedef struct packed {
    logic [23:0] step_time;
    logic [31:0] process_noise;
    logic [31:0] measurement_noise;
    logic [10:0] gyro_fs;
  } cfg_t;

  typedef struct packed {
    logic     valid;
    in_item_t item;
  } queue_head_t;

  typedef enum logic [1:0] {
    REG_STEP_TIME, REG_PROC_NOISE, REG_MEAS_NOISE, REG_GYRO_FS
  } cfg_reg_e;

  typedef enum logic {
    OP_INIT   = 1'b0,
    OP_UPDATE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CORDIC, ST_MUL, ST_PREP, ST_DIV_K0, ST_DIV_K1, ST_OUT
  } back_state_e;

  typedef enum logic [3:0] {
    MS_APRI, MS_DTP11, MS_CROSS, MS_DT2, MS_ANGLE, MS_BIAS, MS_COVA, MS_COVC, MS_COVB
  } mul_step_e;

  // atan(2^-i) in degrees with TBL_FRAC fraction bits
  function automatic logic [31:0] atan_deg(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'd754974720;
      5'd1:  v = 32'd445687602;
      5'd2:  v = 32'd235489088;
      5'd3:  v = 32'd119537938;
      5'd4:  v = 32'd60000934;
      5'd5:  v = 32'd30029717;
      5'd6:  v = 32'd15018523;
      5'd7:  v = 32'd7509720;
      5'd8:  v = 32'd3754917;
      5'd9:  v = 32'd1877466;
      5'd10: v = 32'd938734;
      5'd11: v = 32'd469367;
      5'd12: v = 32'd234684;
      5'd13: v = 32'd117342;
      5'd14: v = 32'd58671;
      5'd15: v = 32'd29335;
      5'd16: v = 32'd14668;
      5'd17: v = 32'd7334;
      5'd18: v = 32'd3667;
      5'd19: v = 32'd1833;
      5'd20: v = 32'd917;
      5'd21: v = 32'd458;
      5'd22: v = 32'd229;
      5'd23: v = 32'd115;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // round to nearest, ties toward plus infinity
  function automatic logic signed [67:0] rshr(input logic signed [67:0] v, input int s);
    logic signed [67:0] r;
    r = (v + (68'sd1 <<< (s - 1))) >>> s;
    return r;
  endfunction

  function automatic logic signed [67:0] sat(input logic signed [67:0] v,
                                             input logic signed [67:0] lo,
                                             input logic signed [67:0] hi);
    logic signed [67:0] r;
    r = (v < lo) ? lo : ((v > hi) ? hi : v);
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/tak_front.sv =====
// Input queue: accepts items and presents the oldest one to the back end.
`default_nettype none
module tak_front import tak_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire in_item_t    item_i,
  output logic             full_o,
  output queue_head_t      head_o,
  input  wire logic        take_i
);

  in_item_t    mem_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;
  logic        do_push, do_take;

  assign full_o      = (cnt_q == 2'd2);
  assign do_push     = push_i && !full_o;
  assign do_take     = take_i && (cnt_q != 2'd0);
  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.item  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_take) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_take};
    end
  end

endmodule
`default_nettype wire

// ===== design/tak_cordic.sv =====
// Iterative vectoring CORDIC giving atan(a/b) in degrees, one stage per cycle.
`default_nettype none
module tak_cordic import tak_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [15:0] a_i,
  input  wire logic signed [15:0] b_i,
  output logic                    done_o,
  output logic signed [24:0]      angle_o
);

  localparam int ANG_SHIFT = TBL_FRAC - FRAC_BITS;

  logic              busy_q, done_q;
  logic signed [43:0] x_q, y_q, x_d, y_d, a_ext, b_ext;
  logic signed [33:0] z_q, z_d, step;
  logic [CNT_W-1:0]  i_q;
  logic signed [24:0] res_q;
  logic signed [67:0] z_rnd;

  assign a_ext = 44'(a_i);
  assign b_ext = 44'(b_i);
  assign step  = $signed({2'b00, atan_deg(5'(i_q))});

  always_comb begin
    if (y_q > 44'sd0) begin
      x_d = x_q + (y_q >>> i_q);
      y_d = y_q - (x_q >>> i_q);
      z_d = z_q + step;
    end else begin
      x_d = x_q - (y_q >>> i_q);
      y_d = y_q + (x_q >>> i_q);
      z_d = z_q - step;
    end
  end

  assign z_rnd   = rshr(68'(z_d), ANG_SHIFT);
  assign done_o  = done_q;
  assign angle_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      x_q    <= '0;
      y_q    <= '0;
      z_q    <= '0;
      i_q    <= '0;
      res_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (b_i == 16'sd0) begin
          // vertical vector: +-90 or zero
          if (a_i > 16'sd0)      res_q <= 25'(90 * (2 ** FRAC_BITS));
          else if (a_i < 16'sd0) res_q <= -25'(90 * (2 ** FRAC_BITS));
          else                   res_q <= '0;
          done_q <= 1'b1;
        end else begin
          x_q    <= ((b_ext < 44'sd0) ? -b_ext : b_ext) <<< TBL_FRAC;
          y_q    <= ((b_ext < 44'sd0) ? -a_ext : a_ext) <<< TBL_FRAC;
          z_q    <= '0;
          i_q    <= '0;
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        x_q <= x_d;
        y_q <= y_d;
        z_q <= z_d;
        i_q <= i_q + 1'b1;
        if (i_q == CNT_W'(CORDIC_STAGES - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
          res_q  <= z_rnd[24:0];
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/tak_div.sv =====
// Restoring divider, one quotient bit per cycle, rounding to nearest.
`default_nettype none
module tak_div import tak_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [47:0] num_i,
  input  wire logic [33:0] den_i,
  output logic             done_o,
  output logic [48:0]      quo_o
);

  logic        busy_q, done_q;
  logic [48:0] n_q;
  logic [33:0] rem_q, den_q;
  logic [5:0]  cnt_q;
  logic [34:0] trial;
  logic        fits;

  assign trial  = {rem_q, n_q[48]};
  assign fits   = (trial >= {1'b0, den_q});
  assign done_o = done_q;
  assign quo_o  = n_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      n_q    <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        // add half the divisor up front for the rounding
        n_q    <= {1'b0, num_i} + {16'd0, den_i[33:1]};
        den_q  <= den_i;
        rem_q  <= '0;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= fits ? 34'(trial - {1'b0, den_q}) : trial[33:0];
        n_q   <= {n_q[47:0], fits};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == 6'd48) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/tak_back.sv =====
// Filter sequencer: CORDIC, predict and correct over a shared multiplier and divider.
`default_nettype none
module tak_back import tak_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire queue_head_t head_i,
  output logic             take_o,
  input  wire cfg_t        cfg_i,
  input  wire logic        pop_i,
  output logic             empty_o,
  output out_item_t        result_o
);

  back_state_e state_q, state_d;
  mul_step_e   mstep_q;
  logic        ph_q;
  logic        op_q;

  logic signed [28:0] u_q;
  logic signed [24:0] angle_q, meas_q;
  logic signed [27:0] bias_q;
  logic [30:0]        pa_q, pb_q;
  logic signed [31:0] pc_q;
  logic signed [31:0] apri_q, dtp11_q, xt_q, yt_q, p00_q, p01_q, p11_q, eps_q;
  logic [33:0]        s_q;
  logic signed [17:0] k0_q;
  logic signed [28:0] k1_q;
  logic signed [65:0] prod_q;
  logic               res_valid_q;
  out_item_t          res_q;

  logic               cor_start, cor_done;
  logic signed [24:0] cor_angle;
  logic               div_start, div_done;
  logic [47:0]        div_num;
  logic [33:0]        div_den;
  logic [48:0]        div_quo;

  logic signed [27:0] gprod;
  logic signed [32:0] mul_a, mul_b, dt33;
  logic signed [67:0] rs24, rs16, p00_raw, p00_c, p01_c, p11_c;
  logic [33:0]        s_d;
  logic [31:0]        p01_abs;
  logic [48:0]        k1_mag;
  logic               last_mul, out_free;

  tak_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .a_i     (head_i.item.accel_a),
    .b_i     (head_i.item.accel_b),
    .done_o  (cor_done),
    .angle_o (cor_angle)
  );

  tak_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign gprod    = head_i.item.gyro_rate * $signed({1'b0, cfg_i.gyro_fs});
  assign dt33     = $signed({9'd0, cfg_i.step_time});
  assign rs24     = rshr(68'(prod_q), TBL_FRAC);
  assign rs16     = rshr(68'(prod_q), FRAC_BITS);
  assign last_mul = ph_q && (mstep_q == MS_COVB);
  assign out_free = !res_valid_q || pop_i;

  // predicted covariance and innovation
  assign p00_raw = $signed(68'(pa_q)) - (68'(xt_q) <<< 1) + 68'(yt_q)
                   + $signed(68'(cfg_i.process_noise));
  assign p00_c   = sat(p00_raw, 68'sd0, I32_MAX);
  assign p01_c   = sat(68'(pc_q) - 68'(dtp11_q), I32_MIN, I32_MAX);
  assign p11_c   = sat($signed(68'(pb_q)) + $signed(68'(cfg_i.process_noise)),
                       68'sd0, I32_MAX);
  assign s_d     = 34'(p00_c) + 34'(cfg_i.measurement_noise);
  assign p01_abs = (p01_q < 32'sd0) ? 32'(-p01_q) : 32'(p01_q);
  assign k1_mag  = (div_quo > K1_LIM) ? K1_LIM : div_quo;

  always_comb begin
    case (mstep_q)
      MS_APRI:  begin mul_a = 33'(u_q) - 33'(bias_q); mul_b = dt33; end
      MS_DTP11: begin mul_a = $signed({2'b00, pb_q}); mul_b = dt33; end
      MS_CROSS: begin mul_a = 33'(pc_q);              mul_b = dt33; end
      MS_DT2:   begin mul_a = 33'(dtp11_q);           mul_b = dt33; end
      MS_ANGLE: begin mul_a = 33'(k0_q);              mul_b = 33'(eps_q); end
      MS_BIAS:  begin mul_a = 33'(k1_q);              mul_b = 33'(eps_q); end
      MS_COVA:  begin mul_a = 33'(k0_q);              mul_b = 33'(p00_q); end
      MS_COVC:  begin mul_a = 33'(k0_q);              mul_b = 33'(p01_q); end
      MS_COVB:  begin mul_a = 33'(k1_q);              mul_b = 33'(p01_q); end
      default:  begin mul_a = '0;                     mul_b = '0; end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (head_i.valid) state_d = ST_CORDIC;
      ST_CORDIC: if (cor_done) state_d = (op_q == OP_INIT) ? ST_OUT : ST_MUL;
      ST_MUL: begin
        if (ph_q && mstep_q == MS_DT2) state_d = ST_PREP;
        else if (last_mul)             state_d = ST_OUT;
      end
      ST_PREP:   state_d = (s_d != 34'd0) ? ST_DIV_K0 : ST_MUL;
      ST_DIV_K0: if (div_done) state_d = ST_DIV_K1;
      ST_DIV_K1: if (div_done) state_d = ST_MUL;
      ST_OUT:    if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    take_o    = (state_q == ST_IDLE) && head_i.valid;
    cor_start = take_o;
    div_start = 1'b0;
    div_num   = 48'(p00_c) << FRAC_BITS;
    div_den   = s_d;
    case (state_q)
      ST_PREP: div_start = (s_d != 34'd0);
      ST_DIV_K0: begin
        div_start = div_done;
        div_num   = 48'(p01_abs) << FRAC_BITS;
        div_den   = s_q;
      end
      default: ;
    endcase
  end

  assign empty_o  = !res_valid_q;
  assign result_o = res_q;

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mstep_q     <= MS_APRI;
      ph_q        <= 1'b0;
      op_q        <= OP_INIT;
      res_valid_q <= 1'b0;
      angle_q     <= '0;
      bias_q      <= '0;
      pa_q        <= 31'(ONE_Q);
      pc_q        <= '0;
      pb_q        <= 31'(ONE_Q);
    end else begin
      state_q <= state_d;
      if (pop_i && res_valid_q) res_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (head_i.valid) begin
            op_q <= head_i.item.operation;
            u_q  <= {gprod, 1'b0};
          end
        end
        ST_CORDIC: begin
          if (cor_done) begin
            meas_q  <= cor_angle;
            mstep_q <= MS_APRI;
            ph_q    <= 1'b0;
            if (op_q == OP_INIT) begin
              angle_q <= 25'(sat(68'(cor_angle), -ALIM, ALIM));
              bias_q  <= '0;
              pa_q    <= 31'(ONE_Q);
              pc_q    <= '0;
              pb_q    <= 31'(ONE_Q);
            end
          end
        end
        ST_MUL: begin
          ph_q <= ~ph_q;
          if (ph_q) begin
            if (!last_mul) mstep_q <= mul_step_e'(mstep_q + 4'd1);
            case (mstep_q)
              MS_APRI:  apri_q  <= 32'(68'(angle_q) + rs24);
              MS_DTP11: dtp11_q <= 32'(rs24);
              MS_CROSS: xt_q    <= 32'(rs24);
              MS_DT2:   yt_q    <= 32'(rs24);
              MS_ANGLE: angle_q <= 25'(sat(68'(apri_q) + rs16, -ALIM, ALIM));
              MS_BIAS:  bias_q  <= 28'(sat(68'(bias_q) + rs16, -BLIM, BLIM));
              MS_COVA:  pa_q    <= 31'(sat(68'(p00_q) - rs16, 68'sd0, I32_MAX));
              MS_COVC:  pc_q    <= 32'(sat(68'(p01_q) - rs16, I32_MIN, I32_MAX));
              MS_COVB:  pb_q    <= 31'(sat(68'(p11_q) - rs16, 68'sd0, I32_MAX));
              default: ;
            endcase
          end
        end
        ST_PREP: begin
          p00_q   <= 32'(p00_c);
          p01_q   <= 32'(p01_c);
          p11_q   <= 32'(p11_c);
          s_q     <= s_d;
          eps_q   <= 32'(meas_q) - apri_q;
          // zero innovation variance: keep the prediction only
          k0_q    <= '0;
          k1_q    <= '0;
          mstep_q <= MS_ANGLE;
          ph_q    <= 1'b0;
        end
        ST_DIV_K0: if (div_done) k0_q <= 18'(div_quo);
        ST_DIV_K1: begin
          if (div_done) begin
            k1_q <= (p01_q < 32'sd0) ? -29'(k1_mag) : 29'(k1_mag);
          end
        end
        ST_OUT: begin
          if (out_free) begin
            res_q.angle_estimate <= angle_q;
            res_q.bias_estimate  <= bias_q;
            res_valid_q          <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/tilt_angle_kalman_filter_unit.sv =====
// Top level of the two-state tilt angle Kalman filter: config registers and block wiring.
//
//  channel   direction  handshake           payload
//  input     in         push / full         in_item_t   (operation, accel_a, accel_b, gyro_rate)
//  result    out        empty / pop         out_item_t  (angle_estimate, bias_estimate)
//  config    in         cfg_we_i            cfg_index_i, cfg_data_i
//
// An init item runs the 16 CORDIC stages plus handoff; an update item runs the CORDIC, two
// 49-step gain divisions (skipped when the innovation variance is zero) and nine passes through
// the shared 33x33 multiplier. Items are processed one at a time; a two-entry input queue
// and a one-entry result register let both sides stall independently.
// Reset is asynchronous: state returns to zero angle and bias with identity covariance.
`default_nettype none
module tilt_angle_kalman_filter_unit import tak_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire in_item_t    in_item_i,
  output logic             empty,
  input  wire logic        pop,
  output out_item_t        result_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  cfg_t        cfg_q;
  queue_head_t head;
  logic        take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_time         <= 24'd83886;
      cfg_q.process_noise     <= 32'd8192;
      cfg_q.measurement_noise <= 32'd65536;
      cfg_q.gyro_fs           <= 11'd250;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_STEP_TIME:  cfg_q.step_time         <= cfg_data_i[23:0];
        REG_PROC_NOISE: cfg_q.process_noise     <= cfg_data_i;
        REG_MEAS_NOISE: cfg_q.measurement_noise <= cfg_data_i;
        REG_GYRO_FS:    cfg_q.gyro_fs           <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  tak_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (in_item_i),
    .full_o (full),
    .head_o (head),
    .take_i (take)
  );

  tak_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .take_o   (take),
    .cfg_i    (cfg_q),
    .pop_i    (pop),
    .empty_o  (empty),
    .result_o (result_o)
  );

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (result_o.angle_estimate <= 25'sd11796480 &&
                result_o.angle_estimate >= -25'sd11796480))
    else $error("angle estimate outside +-180 degrees");

  a_bias_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (result_o.bias_estimate <= 28'sd131072000 &&
                result_o.bias_estimate >= -28'sd131072000))
    else $error("bias estimate outside +-2000 dps");

  a_take_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> head.valid)
    else $error("back end took from an empty queue");

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the tilt angle Kalman filter unit.
`timescale 1ns / 1ps
module testbench;
  import tak_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  in_item_t    in_item_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  out_item_t   result_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  tilt_angle_kalman_filter_unit u_dut (
    .clk_i, .rst_ni, .push, .full, .in_item_i, .empty, .pop, .result_o,
    .cfg_we_i, .cfg_index_i, .cfg_data_i
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  localparam int WATCHDOG_LIMIT = 20000;
  localparam longint ONE = 64'sd1 << 16;
  localparam longint MAX32 = 64'sd2147483647;
  localparam longint MIN32 = -64'sd2147483648;

  // filter copy
  longint m_step, m_q, m_r, m_fs;
  longint m_angle, m_bias, m_pa, m_pc, m_pb;

  out_item_t expected_q[$];
  int        failures = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  bit        recv_hold = 1'b0;
  int        quiet_cycles = 0;

  longint atan_tbl[16] = '{754974720, 445687602, 235489088, 119537938, 60000934,
    30029717, 15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
    117342, 58671, 29335};

  function automatic longint floor_sh(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_sh(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint div_near(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic longint tilt_meas(longint a, longint b);
    longint x, y, z, dx, dy;
    z = 0;
    if (b == 0) return a > 0 ? 90 * ONE : (a < 0 ? -90 * ONE : 0);
    x = (b < 0 ? -b : b) <<< 24;
    y = (b < 0 ? -a : a) <<< 24;
    for (int i = 0; i < 16; i++) begin
      dx = floor_sh(y, i);
      dy = floor_sh(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += atan_tbl[i];
      end else begin
        x -= dx; y += dy; z -= atan_tbl[i];
      end
    end
    return round_sh(z, 8);
  endfunction

  function automatic out_item_t filter_step(in_item_t it);
    longint a, b, g, meas, u, apri, dtp11, p00, p01, p11, s, eps, k0, k1;
    out_item_t r;
    a = longint'(it.accel_a);
    b = longint'(it.accel_b);
    g = longint'(it.gyro_rate);
    meas = tilt_meas(a, b);
    if (it.operation == OP_INIT) begin
      m_angle = clip(meas, -180 * ONE, 180 * ONE);
      m_bias = 0; m_pa = ONE; m_pc = 0; m_pb = ONE;
    end else begin
      k0 = 0; k1 = 0;
      u = round_sh(g * m_fs * ONE, 15);
      apri = m_angle + round_sh((u - m_bias) * m_step, 24);
      dtp11 = round_sh(m_pb * m_step, 24);
      p00 = m_pa - 2 * round_sh(m_pc * m_step, 24) + round_sh(dtp11 * m_step, 24) + m_q;
      p01 = clip(m_pc - dtp11, MIN32, MAX32);
      p11 = clip(m_pb + m_q, 0, MAX32);
      p00 = clip(p00, 0, MAX32);
      s = p00 + m_r;
      eps = clip(meas - apri, -(64'sd1 << 34), 64'sd1 << 34);
      if (s > 0) begin
        k0 = div_near(p00 * ONE, s);
        k1 = clip(div_near(p01 * ONE, s), -(64'sd1 << 27), 64'sd1 << 27);
      end
      m_angle = clip(apri + round_sh(k0 * eps, 16), -180 * ONE, 180 * ONE);
      m_bias = clip(m_bias + round_sh(k1 * eps, 16), -2000 * ONE, 2000 * ONE);
      m_pa = clip(p00 - round_sh(k0 * p00, 16), 0, MAX32);
      m_pc = clip(p01 - round_sh(k0 * p01, 16), MIN32, MAX32);
      m_pb = clip(p11 - round_sh(k1 * p01, 16), 0, MAX32);
    end
    r.angle_estimate = m_angle[24:0];
    r.bias_estimate = m_bias[27:0];
    return r;
  endfunction

  // push stays high across back-to-back items; drain drops it
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (full);
    expected_q.push_back(filter_step(it));
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_STEP_TIME:  m_step = longint'(val[23:0]);
      REG_PROC_NOISE: m_q = longint'(val);
      REG_MEAS_NOISE: m_r = longint'(val);
      REG_GYRO_FS:    m_fs = longint'(val[10:0]);
      default: ;
    endcase
  endtask

  task automatic drain();
    push <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  function automatic in_item_t rand_item(int init_pct);
    in_item_t it;
    it.operation = ($urandom_range(99) < init_pct) ? OP_INIT : OP_UPDATE;
    it.accel_a = 16'($urandom);
    it.accel_b = 16'($urandom);
    it.gyro_rate = 16'($urandom);
    case ($urandom_range(7))
      0: it.accel_b = '0;
      1: it.gyro_rate = 16'($urandom_range(200) - 100);
      2: begin
        it.accel_a = 16'($urandom_range(4000) - 2000);
        it.accel_b = 16'($urandom_range(16000) + 1000);
      end
      default: ;
    endcase
    return it;
  endfunction

  // pop side and result check
  always @(posedge clk_i) begin
    out_item_t want;
    if (pop && !empty) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result %h", result_o);
        failures++;
      end else begin
        want = expected_q.pop_front();
        if (result_o.angle_estimate !== want.angle_estimate) begin
          $error("angle_estimate expected %0d actual %0d",
                 want.angle_estimate, result_o.angle_estimate);
          failures++;
        end
        if (result_o.bias_estimate !== want.bias_estimate) begin
          $error("bias_estimate expected %0d actual %0d",
                 want.bias_estimate, result_o.bias_estimate);
          failures++;
        end
      end
    end
    pop <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || cfg_we_i) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  task automatic test_directed();
    in_item_t it;
    int vals[6] = '{-32768, 32767, 0, 1, -1, 12345};
    for (int i = 0; i < 6; i++) begin
      it.operation = (i % 2) ? OP_UPDATE : OP_INIT;
      it.accel_a = 16'(vals[i]);
      it.accel_b = 16'(vals[(i + 2) % 6]);
      it.gyro_rate = 16'(vals[(i + 1) % 6]);
      send_item(it);
    end
    it = '{OP_INIT, 16'sd100, 16'sd0, 16'sd0};   send_item(it);
    it = '{OP_INIT, -16'sd100, 16'sd0, 16'sd0};  send_item(it);
    it = '{OP_UPDATE, 16'sd0, 16'sd0, 16'sd0};   send_item(it);
    it = '{OP_UPDATE, 16'sh7fff, -16'sh8000, 16'sh7fff}; send_item(it);
    it = '{OP_UPDATE, -16'sh8000, 16'sh7fff, -16'sh8000}; send_item(it);
    it = '{OP_UPDATE, -16'sh8000, -16'sh8000, 16'sh7fff}; send_item(it);
    for (int i = 0; i < 8; i++) send_item(rand_item(20));
    drain();
  endtask

  task automatic test_extreme_config();
    write_reg(REG_STEP_TIME, 32'hFFFFFF);
    write_reg(REG_PROC_NOISE, 32'hFFFFFFFF);
    write_reg(REG_MEAS_NOISE, 32'hFFFFFFFF);
    write_reg(REG_GYRO_FS, 32'd2000);
    for (int i = 0; i < 40; i++) send_item(rand_item(5));
    drain();
    write_reg(REG_STEP_TIME, 32'd1);
    write_reg(REG_PROC_NOISE, 32'd0);
    write_reg(REG_MEAS_NOISE, 32'd1);
    write_reg(REG_GYRO_FS, 32'd125);
    for (int i = 0; i < 40; i++) send_item(rand_item(5));
    drain();
  endtask

  task automatic test_random_phases();
    int idle[4] = '{0, 62, 0, 18};
    int stall[4] = '{0, 0, 62, 18};
    for (int p = 0; p < 4; p++) begin
      write_reg(REG_STEP_TIME, $urandom_range(16777215, 1));
      write_reg(REG_PROC_NOISE, $urandom_range(200000));
      write_reg(REG_MEAS_NOISE, $urandom_range(500000, 1));
      write_reg(REG_GYRO_FS, $urandom_range(2000, 125));
      send_idle_pct = idle[p];
      recv_stall_pct = stall[p];
      for (int i = 0; i < 280; i++) send_item(rand_item(8));
      drain();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    fork
      begin
        recv_hold = 1'b1;
        repeat (1500) @(posedge clk_i);
        recv_hold = 1'b0;
      end
      for (int i = 0; i < 30; i++) send_item(rand_item(10));
    join
    drain();
  endtask

  initial begin
    m_step = 83886; m_q = 8192; m_r = 65536; m_fs = 250;
    m_angle = 0; m_bias = 0; m_pa = ONE; m_pc = 0; m_pb = ONE;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_extreme_config();
    test_backpressure();
    test_random_phases();
    if (failures == 0 && expected_q.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule
